// ===== design/erfr_pkg.sv =====
// erfr_pkg: shared constants and types for the escaped response frame receiver
// no dependencies; imported by erfr_core, erfr_skid and the top level
package erfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 17;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 15;
    localparam int CODE_W  = 2;

    localparam logic [BYTE_W-1:0]  ESC_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0]  SOF_BYTE  = 8'hCC;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // fixed frame positions
    localparam logic [COUNT_W-1:0] POS_FIRST   = 17'd0;
    localparam logic [COUNT_W-1:0] POS_SECOND  = 17'd1;
    localparam logic [COUNT_W-1:0] POS_LEN_HI  = 17'd6;
    localparam logic [COUNT_W-1:0] POS_LEN_LO  = 17'd7;
    localparam logic [COUNT_W-1:0] POS_STATUS  = 17'd8;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD = 17'd9;
    localparam logic [COUNT_W-1:0] POS_RESTART = 17'd2;

    // result codes
    localparam logic [CODE_W-1:0] CODE_PENDING = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OK      = 2'd1;
    localparam logic [CODE_W-1:0] CODE_PARITY  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_SKIPPED = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] frame_code;
        logic              is_data;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  data_index;
        logic [BYTE_W-1:0] resp_status;
        logic [IDX_W-1:0]  payload_len;
    } erfr_result_t;

endpackage

// ===== design/erfr_core.sv =====
// erfr_core: deframer state registers and per-byte next-state and result logic
// depends on erfr_pkg
module erfr_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [erfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       chunk_end,
    output erfr_pkg::erfr_result_t     result
);
    import erfr_pkg::*;

    logic               escape_pending_reg, escape_pending_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]  parity_reg, parity_next;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [BYTE_W-1:0]  second_reg, second_next;
    logic [BYTE_W-1:0]  len_hi_reg, len_hi_next;
    logic [BYTE_W-1:0]  len_lo_reg, len_lo_next;
    logic [BYTE_W-1:0]  status_reg, status_next;
    logic               skip_rest_reg, skip_rest_next;

    logic [LEN_W-1:0]   len_cur, len_new;
    logic               len_cur_ok, len_new_ok;
    logic [COUNT_W-1:0] data_end, done_count, data_pos;

    assign len_cur    = {len_hi_reg, len_lo_reg};
    assign len_new    = {len_hi_next, len_lo_next};
    assign len_cur_ok = (len_cur != '0) && !len_cur[LEN_W-1];
    assign len_new_ok = (len_new != '0) && !len_new[LEN_W-1];
    assign data_end   = {1'b0, len_cur} + 17'd8;
    assign done_count = {1'b0, len_new} + 17'd9;
    assign data_pos   = byte_count_reg - POS_PAYLOAD;

    always_comb begin
        escape_pending_next = escape_pending_reg;
        byte_count_next     = byte_count_reg;
        parity_next         = parity_reg;
        first_next          = first_reg;
        second_next         = second_reg;
        len_hi_next         = len_hi_reg;
        len_lo_next         = len_lo_reg;
        status_next         = status_reg;
        skip_rest_next      = skip_rest_reg;
        result.frame_code   = CODE_PENDING;
        result.is_data      = 1'b0;
        result.data_byte    = '0;
        result.data_index   = '0;

        if (skip_rest_reg) begin
            result.frame_code = CODE_SKIPPED;
            if (chunk_end) begin
                skip_rest_next = 1'b0;
            end
        end else begin
            if (escape_pending_reg) begin
                escape_pending_next = 1'b0;
                // escaped start of frame restarts the header, byte count and parity
                if (rx_byte == SOF_BYTE) begin
                    first_next      = ESC_BYTE;
                    second_next     = SOF_BYTE;
                    byte_count_next = POS_RESTART;
                    parity_next     = '0;
                end
            end else begin
                if (byte_count_reg == POS_FIRST) begin
                    first_next = rx_byte;
                end else if (byte_count_reg == POS_SECOND) begin
                    second_next = rx_byte;
                end else if (byte_count_reg == POS_LEN_HI) begin
                    len_hi_next = rx_byte;
                end else if (byte_count_reg == POS_LEN_LO) begin
                    len_lo_next = rx_byte;
                end else if (byte_count_reg == POS_STATUS) begin
                    status_next = rx_byte;
                end else if (byte_count_reg >= POS_PAYLOAD) begin
                    if (len_cur_ok && (byte_count_reg < data_end)) begin
                        result.is_data    = 1'b1;
                        result.data_byte  = rx_byte;
                        result.data_index = data_pos[IDX_W-1:0];
                    end
                end
                if (byte_count_reg != COUNT_MAX) begin
                    byte_count_next = byte_count_reg + 17'd1;
                end
                parity_next = parity_reg ^ rx_byte;
                if (rx_byte == ESC_BYTE) begin
                    escape_pending_next = 1'b1;
                end
            end

            if ((byte_count_next > POS_PAYLOAD) && (first_next == ESC_BYTE) &&
                (second_next == SOF_BYTE) && len_new_ok &&
                (byte_count_next == done_count)) begin
                result.frame_code = (parity_next == '0) ? CODE_OK : CODE_PARITY;
                if (!chunk_end) begin
                    skip_rest_next = 1'b1;
                end
            end
        end

        result.resp_status = status_next;
        result.payload_len = len_new_ok ? len_new[IDX_W-1:0] - 15'd1 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_pending_reg <= 1'b0;
            byte_count_reg     <= '0;
            parity_reg         <= '0;
            first_reg          <= '0;
            second_reg         <= '0;
            len_hi_reg         <= '0;
            len_lo_reg         <= '0;
            status_reg         <= '0;
            skip_rest_reg      <= 1'b0;
        end else if (fire) begin
            escape_pending_reg <= escape_pending_next;
            byte_count_reg     <= byte_count_next;
            parity_reg         <= parity_next;
            first_reg          <= first_next;
            second_reg         <= second_next;
            len_hi_reg         <= len_hi_next;
            len_lo_reg         <= len_lo_next;
            status_reg         <= status_next;
            skip_rest_reg      <= skip_rest_next;
        end
    end

endmodule

// ===== design/erfr_skid.sv =====
// erfr_skid: result register with one skid entry so input ready is registered
// depends on erfr_pkg
module erfr_skid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  erfr_pkg::erfr_result_t in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output erfr_pkg::erfr_result_t out_data
);
    import erfr_pkg::*;

    logic         out_valid_reg;
    erfr_result_t out_data_reg;
    logic         skid_valid_reg;
    erfr_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up: skid entry goes first
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== design/escaped_response_frame_receiver_unit.sv =====
// channel  | ports                                                 | dir
// s_       | s_valid s_ready s_rx_byte s_chunk_end                 | in
// m_       | m_valid m_ready m_frame_code m_is_data m_data_byte    | out
//          | m_data_index m_resp_status m_payload_len              |
// one byte per cycle while s_ready is high; its result is registered in a result slot
// the frame state updates once for each accepted byte
// synchronous active-low reset clears the frame state and both result slots
// a stalled m_ side fills one skid entry, then s_ready drops until it drains
// top level: depends on erfr_pkg, erfr_core, erfr_skid
module escaped_response_frame_receiver_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [erfr_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                        s_chunk_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [erfr_pkg::CODE_W-1:0] m_frame_code,
    output logic                        m_is_data,
    output logic [erfr_pkg::BYTE_W-1:0] m_data_byte,
    output logic [erfr_pkg::IDX_W-1:0]  m_data_index,
    output logic [erfr_pkg::BYTE_W-1:0] m_resp_status,
    output logic [erfr_pkg::IDX_W-1:0]  m_payload_len
);
    import erfr_pkg::*;

    logic         fire;
    erfr_result_t core_result;
    erfr_result_t out_result;

    assign fire = s_valid && s_ready;

    erfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .rx_byte   (s_rx_byte),
        .chunk_end (s_chunk_end),
        .result    (core_result)
    );

    erfr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (fire),
        .in_data   (core_result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_frame_code  = out_result.frame_code;
    assign m_is_data     = out_result.is_data;
    assign m_data_byte   = out_result.data_byte;
    assign m_data_index  = out_result.data_index;
    assign m_resp_status = out_result.resp_status;
    assign m_payload_len = out_result.payload_len;

endmodule

// ===== sim/escaped_response_frame_receiver_unit_tb.sv =====
// testbench for escaped_response_frame_receiver_unit: byte-stuffed frames, noise and stalls
// depends on erfr_pkg and the receiver RTL; expected results come from a local deframer model
`timescale 1ns / 100ps

module escaped_response_frame_receiver_unit_tb;
    import erfr_pkg::*;

    localparam int RANDOM_ITEMS   = 1725;
    localparam int CALM_LO        = 300;
    localparam int CALM_HI        = 700;
    localparam int PRESSURE_AT    = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              last;
    } rx_txn_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte   = '0;
    logic              s_chunk_end = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [CODE_W-1:0] m_frame_code;
    logic              m_is_data;
    logic [BYTE_W-1:0] m_data_byte;
    logic [IDX_W-1:0]  m_data_index;
    logic [BYTE_W-1:0] m_resp_status;
    logic [IDX_W-1:0]  m_payload_len;

    rx_txn_t      rx_bytes_q[$];
    erfr_result_t frame_results_due[$];
    rx_txn_t      txn_to_drive;
    erfr_result_t want;
    int           bytes_sent    = 0;
    int           results_seen  = 0;
    int           mismatch_count = 0;
    int           stall_left    = 0;
    bit           stall_done    = 1'b0;
    int           quiet_cycles  = 0;

    // deframer state
    logic               esc_armed = 1'b0;
    logic [COUNT_W-1:0] frame_pos = '0;
    logic [BYTE_W-1:0]  xor_acc   = '0;
    logic [BYTE_W-1:0]  hdr0      = '0;
    logic [BYTE_W-1:0]  hdr1      = '0;
    logic [BYTE_W-1:0]  len_hi    = '0;
    logic [BYTE_W-1:0]  len_lo    = '0;
    logic [BYTE_W-1:0]  status_q  = '0;
    logic               skipping  = 1'b0;

    escaped_response_frame_receiver_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_chunk_end   (s_chunk_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_code  (m_frame_code),
        .m_is_data     (m_is_data),
        .m_data_byte   (m_data_byte),
        .m_data_index  (m_data_index),
        .m_resp_status (m_resp_status),
        .m_payload_len (m_payload_len)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit len_ok(input logic [LEN_W-1:0] len);
        return len != '0 && !len[LEN_W-1];
    endfunction

    // advances the deframer by one received byte and returns its result
    function automatic erfr_result_t deframe_byte(input logic [BYTE_W-1:0] b, input logic last);
        erfr_result_t r;
        logic [LEN_W-1:0] len;
        r = '0;
        if (skipping) begin
            r.frame_code = CODE_SKIPPED;
            if (last) skipping = 1'b0;
        end else begin
            if (esc_armed) begin
                esc_armed = 1'b0;
                if (b == SOF_BYTE) begin
                    hdr0      = ESC_BYTE;
                    hdr1      = SOF_BYTE;
                    frame_pos = POS_RESTART;
                    xor_acc   = '0;
                end
            end else begin
                len = {len_hi, len_lo};
                if (frame_pos == POS_FIRST) hdr0 = b;
                else if (frame_pos == POS_SECOND) hdr1 = b;
                else if (frame_pos == POS_LEN_HI) len_hi = b;
                else if (frame_pos == POS_LEN_LO) len_lo = b;
                else if (frame_pos == POS_STATUS) status_q = b;
                else if (frame_pos >= POS_PAYLOAD && len_ok(len)
                         && 32'(frame_pos) < 32'(len) + 32'(POS_STATUS)) begin
                    r.is_data    = 1'b1;
                    r.data_byte  = b;
                    r.data_index = IDX_W'(frame_pos - POS_PAYLOAD);
                end
                if (frame_pos != COUNT_MAX) frame_pos = frame_pos + 1'b1;
                xor_acc = xor_acc ^ b;
                if (b == ESC_BYTE) esc_armed = 1'b1;
            end
            len = {len_hi, len_lo};
            if (frame_pos > POS_PAYLOAD && hdr0 == ESC_BYTE && hdr1 == SOF_BYTE && len_ok(len)
                && 32'(frame_pos) == 32'(len) + 32'(POS_PAYLOAD)) begin
                r.frame_code = (xor_acc == '0) ? CODE_OK : CODE_PARITY;
                if (!last) skipping = 1'b1;
            end
        end
        len = {len_hi, len_lo};
        r.resp_status = status_q;
        r.payload_len = len_ok(len) ? IDX_W'(len - 1'b1) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom);
        case ($urandom_range(15))
            0, 1: v = ESC_BYTE;
            2: v = SOF_BYTE;
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        rx_txn_t t;
        t.rx   = b;
        t.last = last;
        rx_bytes_q.push_back(t);
    endtask

    // an escape byte inside the frame is followed by a stuffing byte that is dropped
    task automatic push_content(input logic [BYTE_W-1:0] b, input logic last);
        logic [BYTE_W-1:0] stuff;
        push_byte(b, last);
        if (b == ESC_BYTE) begin
            stuff = BYTE_W'($urandom);
            if (stuff == SOF_BYTE) stuff = 8'h00;
            push_byte(stuff, 1'b0);
        end
    endtask

    // header, four filler bytes, length, status, nbody bytes of payload and trailer, then
    // tail bytes to be skipped; the trailer closes the chunk when there is no tail
    task automatic send_frame(input logic [LEN_W-1:0] flen, input int nbody, input bit good,
                              input int tail);
        logic [BYTE_W-1:0] par;
        logic [BYTE_W-1:0] b;
        int i;
        par = '0;
        push_byte(ESC_BYTE, 1'b0);
        push_byte(SOF_BYTE, 1'b0);
        for (i = 0; i < 7 + nbody; i++) begin
            if (i == 4) b = flen[15:8];
            else if (i == 5) b = flen[7:0];
            else if (i == 6 + nbody) b = good ? par : par ^ BYTE_W'($urandom_range(255, 1));
            else b = rand_byte();
            par = par ^ b;
            push_content(b, (i == 6 + nbody) ? (tail == 0) : ($urandom_range(99) < 3));
        end
        for (i = 0; i < tail; i++) push_byte(rand_byte(), i == tail - 1);
    endtask

    initial begin : stimulus
        int unsigned sel;
        logic [LEN_W-1:0] flen;

        // good frame of length one that completes mid chunk, then one skipped byte
        push_byte(ESC_BYTE, 1'b0); push_byte(SOF_BYTE, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'h7E, 1'b0); push_byte(8'h85, 1'b0); push_byte(8'h55, 1'b1);
        // escaped payload byte, escape as trailer on chunk end, then the stuffing
        // byte reports the same completed frame again and starts skipping
        push_byte(ESC_BYTE, 1'b0); push_byte(SOF_BYTE, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(ESC_BYTE, 1'b0); push_byte(8'h77, 1'b0);
        push_byte(ESC_BYTE, 1'b1); push_byte(8'h10, 1'b0); push_byte(8'h3C, 1'b1);

        while (rx_bytes_q.size() < RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
                flen = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(80, 13))
                                                : LEN_W'($urandom_range(12, 1));
                send_frame(flen, flen, $urandom_range(3) != 0, $urandom_range(3));
            end else if (sel < 75) begin
                flen = LEN_W'($urandom);
                flen[LEN_W-1] = 1'b1;
                if ($urandom_range(1) == 0) flen = '0;
                send_frame(flen, $urandom_range(12), 1'b0, 0);
            end else if (sel < 87) begin
                // cut short, so the next header restarts the frame
                flen = LEN_W'($urandom_range(20, 2));
                send_frame(flen, $urandom_range(flen - 1), 1'b1, 0);
            end else begin
                repeat ($urandom_range(6, 1)) push_byte(rand_byte(), $urandom_range(3) == 0);
            end
        end
        // a few short good frames to close the run
        repeat (3) send_frame(16'd5, 5, 1'b1, 1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (rx_bytes_q.size() != 0 || s_valid) @(posedge aclk);
        while (frame_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("escaped_response_frame_receiver_unit_tb OK");
        else
            $display("escaped_response_frame_receiver_unit_tb NOT OK");
        $finish;
    end

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                frame_results_due.push_back(deframe_byte(s_rx_byte, s_chunk_end));
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (rx_bytes_q.size() != 0 && ((bytes_sent >= CALM_LO && bytes_sent < CALM_HI)
                                               || $urandom_range(99) >= 15)) begin
                    txn_to_drive = rx_bytes_q.pop_front();
                    s_rx_byte   <= txn_to_drive.rx;
                    s_chunk_end <= txn_to_drive.last;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!stall_done && results_seen >= PRESSURE_AT) begin
            stall_done <= 1'b1;
            stall_left <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= (results_seen >= CALM_LO && results_seen < CALM_HI)
                       || $urandom_range(99) >= 15;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (frame_results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with no transaction pending", results_seen));
            end else begin
                want = frame_results_due.pop_front();
                if (m_frame_code !== want.frame_code)
                    report_mismatch($sformatf("result %0d frame_code %0d, want %0d",
                                              results_seen, m_frame_code, want.frame_code));
                if (m_is_data !== want.is_data)
                    report_mismatch($sformatf("result %0d is_data %0d, want %0d",
                                              results_seen, m_is_data, want.is_data));
                if (m_data_byte !== want.data_byte)
                    report_mismatch($sformatf("result %0d data_byte %02h, want %02h",
                                              results_seen, m_data_byte, want.data_byte));
                if (m_data_index !== want.data_index)
                    report_mismatch($sformatf("result %0d data_index %0d, want %0d",
                                              results_seen, m_data_index, want.data_index));
                if (m_resp_status !== want.resp_status)
                    report_mismatch($sformatf("result %0d resp_status %02h, want %02h",
                                              results_seen, m_resp_status, want.resp_status));
                if (m_payload_len !== want.payload_len)
                    report_mismatch($sformatf("result %0d payload_len %0d, want %0d",
                                              results_seen, m_payload_len, want.payload_len));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t timeout with %0d results pending", $time, frame_results_due.size());
            $display("escaped_response_frame_receiver_unit_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
